>>> rtl/tbse_pkg.sv
// Shared types, constants and the element type table for the tensor byte size estimator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package tbse_pkg;

    localparam int DIM_W      = 64;
    localparam int TYPE_W     = 8;
    localparam int CNT_W      = 3;
    localparam int SH_W       = 4;
    localparam int BYTES_W    = 8;
    localparam int NUM_DIM_IN = 4;
    localparam int HALF_W     = DIM_W / 2;
    localparam int PROD_W     = DIM_W + BYTES_W;

    // stream payload widths: dim_count then four dimensions, padded to bytes
    localparam int S_DATA_RAW = CNT_W + NUM_DIM_IN * DIM_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;

    // log2 of the block size
    localparam logic [SH_W-1:0] SH_BLK1   = SH_W'(0);
    localparam logic [SH_W-1:0] SH_BLK32  = SH_W'(5);
    localparam logic [SH_W-1:0] SH_BLK256 = SH_W'(8);

    typedef struct packed {
        logic               known;
        logic [SH_W-1:0]    sh;
        logic [BYTES_W-1:0] bytes;
    } tinfo_t;

    // context carried down the pipeline with each descriptor
    typedef struct packed {
        logic                               ok;
        logic [CNT_W-1:0]                   n;
        logic [SH_W-1:0]                    sh;
        logic [BYTES_W-1:0]                 bytes;
        logic [DIM_W-1:0]                   acc;
        logic [NUM_DIM_IN-2:0][DIM_W-1:0]   rest;
    } ctx_t;

    typedef struct packed {
        logic [DIM_W-1:0] byte_count;
        logic             known;
    } result_t;

    function automatic tinfo_t type_info(input logic [TYPE_W-1:0] id);
        tinfo_t t;
        t.known = 1'b1;
        t.sh    = SH_BLK1;
        t.bytes = '0;
        case (id)
            8'd0:  begin t.sh = SH_BLK1;   t.bytes = 8'd4;   end
            8'd1:  begin t.sh = SH_BLK1;   t.bytes = 8'd2;   end
            8'd2:  begin t.sh = SH_BLK32;  t.bytes = 8'd18;  end
            8'd3:  begin t.sh = SH_BLK32;  t.bytes = 8'd20;  end
            8'd6:  begin t.sh = SH_BLK32;  t.bytes = 8'd22;  end
            8'd7:  begin t.sh = SH_BLK32;  t.bytes = 8'd24;  end
            8'd8:  begin t.sh = SH_BLK32;  t.bytes = 8'd34;  end
            8'd9:  begin t.sh = SH_BLK32;  t.bytes = 8'd36;  end
            8'd10: begin t.sh = SH_BLK256; t.bytes = 8'd84;  end
            8'd11: begin t.sh = SH_BLK256; t.bytes = 8'd110; end
            8'd12: begin t.sh = SH_BLK256; t.bytes = 8'd144; end
            8'd13: begin t.sh = SH_BLK256; t.bytes = 8'd176; end
            8'd14: begin t.sh = SH_BLK256; t.bytes = 8'd210; end
            8'd16: begin t.sh = SH_BLK256; t.bytes = 8'd66;  end
            8'd17: begin t.sh = SH_BLK256; t.bytes = 8'd74;  end
            8'd18: begin t.sh = SH_BLK256; t.bytes = 8'd98;  end
            8'd19: begin t.sh = SH_BLK256; t.bytes = 8'd50;  end
            8'd20: begin t.sh = SH_BLK32;  t.bytes = 8'd18;  end
            8'd21: begin t.sh = SH_BLK256; t.bytes = 8'd110; end
            8'd22: begin t.sh = SH_BLK256; t.bytes = 8'd82;  end
            8'd23: begin t.sh = SH_BLK256; t.bytes = 8'd136; end
            8'd24: begin t.sh = SH_BLK1;   t.bytes = 8'd1;   end
            8'd25: begin t.sh = SH_BLK1;   t.bytes = 8'd2;   end
            8'd26: begin t.sh = SH_BLK1;   t.bytes = 8'd4;   end
            8'd27: begin t.sh = SH_BLK1;   t.bytes = 8'd8;   end
            8'd28: begin t.sh = SH_BLK1;   t.bytes = 8'd8;   end
            8'd29: begin t.sh = SH_BLK256; t.bytes = 8'd56;  end
            8'd30: begin t.sh = SH_BLK1;   t.bytes = 8'd2;   end
            default: begin t.known = 1'b0; end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tbse_front.sv
// First stage: type lookup, count check and round-up of the first dimension.
// Depends on tbse_pkg.
`default_nettype none

module tbse_front #(
    parameter int DIM_LIMIT = 4
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             en,
    input  wire                             in_valid,
    input  wire [tbse_pkg::TYPE_W-1:0]      type_id,
    input  wire [tbse_pkg::CNT_W-1:0]       dim_count,
    input  wire [tbse_pkg::NUM_DIM_IN-1:0][tbse_pkg::DIM_W-1:0] dims,
    output logic                            out_valid,
    output tbse_pkg::ctx_t                  out_ctx
);
    import tbse_pkg::*;

    logic             valid_reg;
    ctx_t             ctx_reg, ctx_next;
    tinfo_t           ti;
    logic [DIM_W-1:0] blk_m1;
    logic             cnt_ok;
    logic             rnd_ovf;

    always_comb begin
        ti      = type_info(type_id);
        blk_m1  = (DIM_W'(1) << ti.sh) - DIM_W'(1);
        cnt_ok  = (dim_count != '0) && (dim_count <= CNT_W'(DIM_LIMIT));
        // d + (blk-1) overflows exactly when d > ~(blk-1)
        rnd_ovf = dims[0] > ~blk_m1;

        ctx_next.ok    = ti.known && cnt_ok && !rnd_ovf;
        ctx_next.n     = dim_count;
        ctx_next.sh    = ti.sh;
        ctx_next.bytes = ti.bytes;
        ctx_next.acc   = (dims[0] + blk_m1) & ~blk_m1;
        for (int i = 0; i < NUM_DIM_IN - 1; i++) begin
            ctx_next.rest[i] = dims[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= ctx_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;

endmodule

`default_nettype wire

>>> rtl/tbse_mul_step.sv
// One checked 64x64 multiply of the running product by a further dimension,
// split over two stages of 32x32 partial products. Depends on tbse_pkg.
`default_nettype none

module tbse_mul_step #(
    parameter int STEP = 1
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             en,
    input  wire             in_valid,
    input  tbse_pkg::ctx_t  in_ctx,
    output logic            out_valid,
    output tbse_pkg::ctx_t  out_ctx
);
    import tbse_pkg::*;

    localparam int IDX = STEP - 1;

    logic              a_valid_reg, b_valid_reg;
    ctx_t              a_ctx_reg, b_ctx_reg, b_ctx_next;
    logic              a_act_reg, a_act_next;
    logic              a_both_reg, a_both_next;
    logic [DIM_W-1:0]  a_lo_reg, a_lo_next;
    logic [DIM_W-1:0]  a_cross_reg, a_cross_next;
    logic [DIM_W-1:0]  dim_b;
    logic [HALF_W-1:0] ah, al, bh, bl, xm, ym;
    logic [DIM_W:0]    sum;
    logic              ovf;

    // stage A: partial products
    always_comb begin
        dim_b = in_ctx.rest[IDX];
        ah    = in_ctx.acc[DIM_W-1:HALF_W];
        al    = in_ctx.acc[HALF_W-1:0];
        bh    = dim_b[DIM_W-1:HALF_W];
        bl    = dim_b[HALF_W-1:0];
        // at most one high half may be nonzero without overflow
        if (ah != '0) begin
            xm = ah;
            ym = bl;
        end else begin
            xm = al;
            ym = bh;
        end
        a_act_next   = in_ctx.ok && (in_ctx.n > CNT_W'(STEP));
        a_both_next  = (ah != '0) && (bh != '0);
        a_lo_next    = DIM_W'(al) * DIM_W'(bl);
        a_cross_next = DIM_W'(xm) * DIM_W'(ym);
    end

    // stage B: combine and check
    always_comb begin
        sum = {1'b0, a_lo_reg} + {1'b0, a_cross_reg[HALF_W-1:0], {HALF_W{1'b0}}};
        ovf = a_both_reg || (a_cross_reg[DIM_W-1:HALF_W] != '0) || sum[DIM_W];
        b_ctx_next = a_ctx_reg;
        if (a_act_reg) begin
            b_ctx_next.acc = sum[DIM_W-1:0];
            b_ctx_next.ok  = !ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctx_reg   <= in_ctx;
            a_act_reg   <= a_act_next;
            a_both_reg  <= a_both_next;
            a_lo_reg    <= a_lo_next;
            a_cross_reg <= a_cross_next;
            b_ctx_reg   <= b_ctx_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_ctx   = b_ctx_reg;

endmodule

`default_nettype wire

>>> rtl/tbse_scale.sv
// Block count times bytes per block, with the final overflow check.
// Depends on tbse_pkg.
`default_nettype none

module tbse_scale (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  tbse_pkg::ctx_t      in_ctx,
    output logic                out_valid,
    output tbse_pkg::result_t   out_res
);
    import tbse_pkg::*;

    logic              valid_reg;
    logic              ok_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DIM_W-1:0]  blocks;
    logic              good;

    always_comb begin
        blocks    = in_ctx.acc >> in_ctx.sh;
        prod_next = PROD_W'(blocks) * PROD_W'(in_ctx.bytes);
        good      = ok_reg && (prod_reg[PROD_W-1:DIM_W] == '0);
        out_res.known      = good;
        out_res.byte_count = good ? prod_reg[DIM_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg   <= in_ctx.ok;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/tbse_out_skid.sv
// Output register with a skid entry; its fill state gates the pipeline.
// Depends on tbse_pkg.
`default_nettype none

module tbse_out_skid (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 tail_valid,
    input  tbse_pkg::result_t   tail_res,
    output logic                pipe_en,
    output logic                m_valid,
    input  wire                 m_ready,
    output tbse_pkg::result_t   m_res
);
    import tbse_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_full_reg, skid_full_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    tail_in;
    logic    out_load;

    always_comb begin
        tail_in        = tail_valid && !skid_full_reg;
        out_load       = !out_valid_reg || m_ready;
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        out_next       = out_reg;
        skid_next      = skid_reg;
        if (out_load) begin
            if (skid_full_reg) begin
                out_next       = skid_reg;
                out_valid_next = 1'b1;
                skid_full_next = 1'b0;
            end else begin
                out_next       = tail_res;
                out_valid_next = tail_in;
            end
        end else if (tail_in) begin
            skid_next      = tail_res;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pipe_en = !skid_full_reg;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

`default_nettype wire

>>> rtl/tensor_byte_size_estimator.sv
// Top level of the tensor byte size estimator: front stage, multiply chain,
// scale stage and output skid. Depends on tbse_pkg and all tbse_* modules.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tuser: type_id; s_tdata: count + 4 dims
//  m_       | out | m_tvalid/m_tready  | m_tdata: byte_count; m_tuser: known
//
// One descriptor beat is taken every cycle while s_tready is high. A beat is
// registered in the front stage, in each dimension step (a two-stage 32x32
// partial-product multiplier), in the scale stage and in the output register.
// aresetn (synchronous, active low) clears only the valid bits and skid state.
// On a stall at m_ tready the output register and skid entry absorb one beat;
// once the skid fills, s_tready drops and the whole pipeline holds in place.
`default_nettype none

module tensor_byte_size_estimator #(
    parameter int MAX_DIMS = 4
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // input descriptor beats
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [tbse_pkg::S_DATA_W-1:0]    s_tdata,  // dim_count, dim_first, dim_second,
                                                      // dim_third, dim_fourth, zero pad
    input  wire [tbse_pkg::TYPE_W-1:0]      s_tuser,  // type_id
    // result beats
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [tbse_pkg::DIM_W-1:0]      m_tdata,  // byte_count
    output logic [0:0]                      m_tuser   // known
);
    import tbse_pkg::*;

    localparam int DIM_LIMIT = (MAX_DIMS < NUM_DIM_IN) ? MAX_DIMS : NUM_DIM_IN;
    localparam int NUM_STEPS = DIM_LIMIT - 1;

    logic                               pipe_en;
    logic [NUM_DIM_IN-1:0][DIM_W-1:0]   dims;
    logic [NUM_STEPS:0]                 chain_valid;
    ctx_t                               chain_ctx [NUM_STEPS+1];
    logic                               tail_valid;
    result_t                            tail_res;
    result_t                            m_res;

    // unpack the dimensions above dim_count
    always_comb begin
        for (int i = 0; i < NUM_DIM_IN; i++) begin
            dims[i] = s_tdata[CNT_W + i*DIM_W +: DIM_W];
        end
    end

    assign s_tready = pipe_en;

    // lookup, count check and round-up
    tbse_front #(
        .DIM_LIMIT (DIM_LIMIT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .type_id   (s_tuser),
        .dim_count (s_tdata[CNT_W-1:0]),
        .dims      (dims),
        .out_valid (chain_valid[0]),
        .out_ctx   (chain_ctx[0])
    );

    // one checked multiply per further dimension
    for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
        tbse_mul_step #(
            .STEP (k)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (chain_valid[k-1]),
            .in_ctx    (chain_ctx[k-1]),
            .out_valid (chain_valid[k]),
            .out_ctx   (chain_ctx[k])
        );
    end

    // divide by block size and scale by bytes per block
    tbse_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (chain_valid[NUM_STEPS]),
        .in_ctx    (chain_ctx[NUM_STEPS]),
        .out_valid (tail_valid),
        .out_res   (tail_res)
    );

    // hold results for the consumer; drop s_tready only when the skid is full
    tbse_out_skid u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tail_valid (tail_valid),
        .tail_res   (tail_res),
        .pipe_en    (pipe_en),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata    = m_res.byte_count;
    assign m_tuser[0] = m_res.known;

endmodule

`default_nettype wire

>>> sim/tensor_byte_size_estimator_tb.sv
// Self-checking testbench for tensor_byte_size_estimator: directed corner cases, then random
// descriptors at full rate and with random idling on both stream sides, and one long output hold-off.
// Depends on rtl/tbse_pkg.sv and rtl/tensor_byte_size_estimator.sv.
`default_nettype none

module tensor_byte_size_estimator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tbse_pkg::*;

    localparam int MAX_DIMS      = 4;
    localparam int IDLE_PCT      = 27;
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;

    // element type ids used by name in the directed cases
    localparam logic [TYPE_W-1:0] TYPE_FIRST     = 8'd0;   // block 1, 4 bytes
    localparam logic [TYPE_W-1:0] TYPE_B32_18    = 8'd2;   // block 32, 18 bytes
    localparam logic [TYPE_W-1:0] TYPE_GAP_A     = 8'd4;   // no entry
    localparam logic [TYPE_W-1:0] TYPE_GAP_B     = 8'd5;   // no entry
    localparam logic [TYPE_W-1:0] TYPE_B256_84   = 8'd10;  // block 256, 84 bytes
    localparam logic [TYPE_W-1:0] TYPE_B256_210  = 8'd14;  // block 256, 210 bytes
    localparam logic [TYPE_W-1:0] TYPE_HOLE      = 8'd15;  // no entry
    localparam logic [TYPE_W-1:0] TYPE_B1_1      = 8'd24;  // block 1, 1 byte
    localparam logic [TYPE_W-1:0] TYPE_B1_8      = 8'd27;  // block 1, 8 bytes
    localparam logic [TYPE_W-1:0] TYPE_LAST      = 8'd30;  // last table entry
    localparam logic [TYPE_W-1:0] TYPE_PAST_END  = 8'd31;  // first id past the table
    localparam logic [TYPE_W-1:0] TYPE_TOP       = 8'd255;

    localparam logic [DIM_W-1:0] ALL_ONES = {DIM_W{1'b1}};

    typedef struct packed {
        logic [TYPE_W-1:0]                  type_id;
        logic [CNT_W-1:0]                   dim_count;
        logic [NUM_DIM_IN-1:0][DIM_W-1:0]   dims;       // dims[0] is dim_first
    } tensor_desc_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [TYPE_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [DIM_W-1:0]       m_tdata;
    logic [0:0]             m_tuser;

    result_t                pending_sizes[$];
    result_t                oldest_size;
    int                     mismatch_count;
    int                     cycles;
    int                     held;
    bit                     tx_idle_en;
    bit                     rx_idle_en;
    bit                     hold_req;
    bit                     hold_done;

    tensor_byte_size_estimator #(
        .MAX_DIMS (MAX_DIMS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Size in bytes of one descriptor; any invalid input or 64-bit overflow gives zero, unknown.
    function automatic result_t predict_byte_size(input tensor_desc_t d);
        logic [DIM_W-1:0]   blk;
        logic [DIM_W-1:0]   bpb;
        logic [DIM_W-1:0]   acc;
        logic [2*DIM_W-1:0] wide;
        result_t            r;
        int                 i;
        r   = '0;
        blk = '0;
        bpb = '0;
        case (d.type_id)
            8'd0:  begin blk = 1;   bpb = 4;   end
            8'd1:  begin blk = 1;   bpb = 2;   end
            8'd2:  begin blk = 32;  bpb = 18;  end
            8'd3:  begin blk = 32;  bpb = 20;  end
            8'd6:  begin blk = 32;  bpb = 22;  end
            8'd7:  begin blk = 32;  bpb = 24;  end
            8'd8:  begin blk = 32;  bpb = 34;  end
            8'd9:  begin blk = 32;  bpb = 36;  end
            8'd10: begin blk = 256; bpb = 84;  end
            8'd11: begin blk = 256; bpb = 110; end
            8'd12: begin blk = 256; bpb = 144; end
            8'd13: begin blk = 256; bpb = 176; end
            8'd14: begin blk = 256; bpb = 210; end
            8'd16: begin blk = 256; bpb = 66;  end
            8'd17: begin blk = 256; bpb = 74;  end
            8'd18: begin blk = 256; bpb = 98;  end
            8'd19: begin blk = 256; bpb = 50;  end
            8'd20: begin blk = 32;  bpb = 18;  end
            8'd21: begin blk = 256; bpb = 110; end
            8'd22: begin blk = 256; bpb = 82;  end
            8'd23: begin blk = 256; bpb = 136; end
            8'd24: begin blk = 1;   bpb = 1;   end
            8'd25: begin blk = 1;   bpb = 2;   end
            8'd26: begin blk = 1;   bpb = 4;   end
            8'd27: begin blk = 1;   bpb = 8;   end
            8'd28: begin blk = 1;   bpb = 8;   end
            8'd29: begin blk = 256; bpb = 56;  end
            8'd30: begin blk = 1;   bpb = 2;   end
            default: begin blk = '0; end
        endcase
        if (blk == 0)
            return r;
        if (d.dim_count == 0 || d.dim_count > MAX_DIMS || d.dim_count > NUM_DIM_IN)
            return r;
        // rounding the first dimension up must not wrap
        if (d.dims[0] > ALL_ONES - (blk - 1))
            return r;
        acc = ((d.dims[0] + blk - 1) / blk) * blk;
        // steps are checked in order: an overflow ahead of a zero dimension still counts
        for (i = 1; i < d.dim_count; i++) begin
            wide = {{DIM_W{1'b0}}, acc} * {{DIM_W{1'b0}}, d.dims[i]};
            if (wide[2*DIM_W-1:DIM_W] != 0)
                return r;
            acc = wide[DIM_W-1:0];
        end
        wide = {{DIM_W{1'b0}}, acc / blk} * {{DIM_W{1'b0}}, bpb};
        if (wide[2*DIM_W-1:DIM_W] != 0)
            return r;
        r.byte_count = wide[DIM_W-1:0];
        r.known      = 1'b1;
        return r;
    endfunction

    function automatic tensor_desc_t make_desc(input logic [TYPE_W-1:0] id,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic [DIM_W-1:0] d0,
                                               input logic [DIM_W-1:0] d1,
                                               input logic [DIM_W-1:0] d2,
                                               input logic [DIM_W-1:0] d3);
        tensor_desc_t d;
        d.type_id   = id;
        d.dim_count = cnt;
        d.dims[0]   = d0;
        d.dims[1]   = d1;
        d.dims[2]   = d2;
        d.dims[3]   = d3;
        return d;
    endfunction

    // Mix of magnitudes: mostly small so products often fit, some full width, some edges.
    function automatic logic [DIM_W-1:0] random_dim();
        logic [DIM_W-1:0] v;
        int               sel;
        int               w;
        sel = $urandom_range(0, 99);
        v   = {$urandom, $urandom};
        if (sel < 45) begin
            w = $urandom_range(0, 14);
            v = v & ((64'd1 << w) - 1);
        end else if (sel < 70) begin
            w = $urandom_range(1, 64);
            if (w < DIM_W)
                v = v & ((64'd1 << w) - 1);
        end else if (sel < 80) begin
            w = $urandom_range(0, DIM_W - 1);
            v = (64'd1 << w) + $urandom_range(0, 2) - 1;
        end else if (sel < 90) begin
            v = $urandom_range(0, 1);
        end else begin
            v = ALL_ONES - $urandom_range(0, 300);
        end
        return v;
    endfunction

    // Well-formed descriptors carry a table id and a legal count; the rest is noise.
    function automatic tensor_desc_t random_desc(input bit well_formed);
        tensor_desc_t d;
        int           i;
        for (i = 0; i < NUM_DIM_IN; i++)
            d.dims[i] = random_dim();
        if (well_formed) begin
            d.type_id = $urandom_range(TYPE_FIRST, TYPE_LAST);
            while (d.type_id == TYPE_GAP_A || d.type_id == TYPE_GAP_B || d.type_id == TYPE_HOLE)
                d.type_id = $urandom_range(TYPE_FIRST, TYPE_LAST);
            d.dim_count = $urandom_range(1, MAX_DIMS);
        end else begin
            d.type_id   = $urandom_range(0, 255);
            d.dim_count = $urandom_range(0, 7);
        end
        return d;
    endfunction

    // Offer one beat from a falling edge, hold it until accepted, then queue its size.
    task automatic send_descriptor(input tensor_desc_t d);
        logic [S_DATA_W-1:0] beat;
        int                  i;
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        beat              = '0;
        beat[CNT_W-1:0]   = d.dim_count;
        for (i = 0; i < NUM_DIM_IN; i++)
            beat[CNT_W + i*DIM_W +: DIM_W] = d.dims[i];
        s_tvalid <= 1'b1;
        s_tuser  <= d.type_id;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_sizes = {pending_sizes, predict_byte_size(d)};
        @(negedge aclk);
    endtask

    task automatic send_random(input int count, input int noise_pct);
        int n;
        for (n = 0; n < count; n++)
            send_descriptor(random_desc($urandom_range(0, 99) >= noise_pct));
    endtask

    task automatic test_directed_cases();
        send_descriptor(make_desc(TYPE_FIRST, 1, 0, 0, 0, 0));           // zero size, known
        send_descriptor(make_desc(TYPE_FIRST, 1, 1, ALL_ONES, ALL_ONES, ALL_ONES));
        send_descriptor(make_desc(TYPE_LAST, 4, 3, 5, 7, 9));
        // unknown ids: holes in the table, first id past it, top id
        send_descriptor(make_desc(TYPE_GAP_A, 1, 10, 0, 0, 0));
        send_descriptor(make_desc(TYPE_GAP_B, 2, 10, 10, 0, 0));
        send_descriptor(make_desc(TYPE_HOLE, 1, 10, 0, 0, 0));
        send_descriptor(make_desc(TYPE_PAST_END, 1, 10, 0, 0, 0));
        send_descriptor(make_desc(TYPE_TOP, 1, 10, 0, 0, 0));
        // invalid counts
        send_descriptor(make_desc(TYPE_B32_18, 0, 64, 2, 2, 2));
        send_descriptor(make_desc(TYPE_B32_18, 5, 64, 2, 2, 2));
        send_descriptor(make_desc(TYPE_B32_18, 7, 64, 2, 2, 2));
        // rounding wraps, rounding just fits but the byte multiply wraps, then byte multiplies at the 64-bit edge
        send_descriptor(make_desc(TYPE_B32_18, 1, ALL_ONES, 0, 0, 0));
        send_descriptor(make_desc(TYPE_B32_18, 1, ALL_ONES - 31, 0, 0, 0));
        send_descriptor(make_desc(TYPE_B1_1, 1, ALL_ONES, 0, 0, 0));
        send_descriptor(make_desc(TYPE_B1_8, 1, 64'd1 << 61, 0, 0, 0));
        send_descriptor(make_desc(TYPE_B1_8, 1, (64'd1 << 61) - 1, 0, 0, 0));
        // product right at the 64-bit edge
        send_descriptor(make_desc(TYPE_B1_1, 2, 64'd1 << 32, 64'd1 << 32, 0, 0));
        send_descriptor(make_desc(TYPE_B1_1, 2, 64'd1 << 32, (64'd1 << 32) - 1, 0, 0));
        // overflow ahead of a zero dimension, and zero ahead of huge dimensions
        send_descriptor(make_desc(TYPE_B1_1, 3, 64'd1 << 40, 64'd1 << 40, 0, 0));
        send_descriptor(make_desc(TYPE_B1_1, 3, 0, ALL_ONES, ALL_ONES, 0));
        // unused dimensions are ignored; first dimension rounds up to the block
        send_descriptor(make_desc(TYPE_B256_210, 1, 1000, ALL_ONES, ALL_ONES, ALL_ONES));
        send_descriptor(make_desc(TYPE_B256_84, 2, 1, 3, ALL_ONES, ALL_ONES));
        send_descriptor(make_desc(TYPE_TOP, 7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    endtask

    // Full-rate stream: no idling on either side.
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random(200, 20);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Hold the output off for a long stretch while beats keep coming, so the input stalls.
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        send_random(60, 10);
        while (!hold_done)
            @(negedge aclk);
        hold_req   = 1'b0;
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_mix();
        send_random(1000, 20);
    endtask

    // Output side: random or constant ready, one counted hold-off on request.
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        held      = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge aclk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (rx_idle_en) begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [DIM_W-1:0] want,
                                 input logic [DIM_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // Compare each result beat with the oldest pending size.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sizes.size() == 0) begin
                note_mismatch("unexpected beat, byte_count", '0, m_tdata);
            end else begin
                oldest_size = pending_sizes.pop_front();
                if (m_tdata !== oldest_size.byte_count)
                    note_mismatch("byte_count", oldest_size.byte_count, m_tdata);
                if (m_tuser[0] !== oldest_size.known)
                    note_mismatch("known", oldest_size.known, m_tuser[0]);
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatch_count = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        hold_req       = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_back_to_back();
        test_output_backpressure();
        test_random_mix();
        s_tvalid <= 1'b0;

        // drain, then give stray beats a chance to show up
        while (pending_sizes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/tbse_pkg.sv
rtl/tbse_front.sv
rtl/tbse_mul_step.sv
rtl/tbse_scale.sv
rtl/tbse_out_skid.sv
rtl/tensor_byte_size_estimator.sv
sim/tensor_byte_size_estimator_tb.sv
